// ----- rtl/acfp_pkg.sv -----
// Shared types and constants for the addressed command frame parser.
package acfp_pkg;

	// Result status codes
	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_SUM  = 2'd1;
	localparam logic [1:0] ST_ADDR = 2'd2;
	localparam logic [1:0] ST_CMD  = 2'd3;

	// Number of key bytes carried on the result
	localparam int OUT_KEYS = 5;

	// Configuration register indexes (byte address / 4)
	localparam int REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_LOCAL_ADDRESS  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_REQUEST_HEADER = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_CMD_SET_KEYS   = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_CMD_STOP_RESET = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_CMD_GET_STATUS = 3'd4;
	localparam int PADDR_W = REG_IDX_W + 2;

	typedef struct packed {
		logic [7:0] rx_byte;
		logic       frame_end;
	} in_t;

	typedef struct packed {
		logic [1:0] status;
		logic [7:0] frame_address;
		logic [7:0] frame_command;
		logic [7:0] key_zero;
		logic [7:0] key_one;
		logic [7:0] key_two;
		logic [7:0] key_three;
		logic [7:0] key_four;
	} out_t;

endpackage

// ----- rtl/addressed_command_frame_parser.sv -----
// Addressed command frame parser: byte-wise frame capture, checksum and address/command check.
//
//  channel  | direction | handshake         | payload
//  ---------+-----------+-------------------+----------------------------------
//  in       | input     | in_valid/in_stall | in_data  (rx_byte, frame_end)
//  out      | output    | out_valid/out_stall| out_data (status, address, cmd, keys)
//  apb      | input     | psel/penable      | paddr, pwdata, prdata
//
// One byte is taken per cycle while in_stall is low; a byte marked frame_end puts its result
// in the output register, or in the skid entry if a stalled result holds the output register.
// The path is one add and a few byte compares. A skid entry behind the output register lets
// bytes keep flowing while a result waits; in_stall rises only while that skid entry is full.
// Reset clears the byte count, running sum, the captured header, address, command
// and check bytes, and the registers; key bytes and result data are not reset,
// and no clearing pass is needed.
module addressed_command_frame_parser
	import acfp_pkg::*;
#(
	parameter int KEY_COUNT = 5
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_stall,
	input  in_t                in_data,
	output logic               out_valid,
	input  logic               out_stall,
	output out_t               out_data,
	input  logic               psel,
	input  logic               penable,
	input  logic               pwrite,
	input  logic [PADDR_W-1:0] paddr,
	input  logic [31:0]        pwdata,
	output logic [31:0]        prdata,
	output logic               pready
);

	localparam int FRAME_LEN = KEY_COUNT + 4;
	localparam int CNT_W     = $clog2(FRAME_LEN + 2);

	// Configuration registers
	logic [7:0] local_address_q;
	logic [7:0] request_header_q;
	logic [7:0] cmd_set_keys_q;
	logic [7:0] cmd_stop_reset_q;
	logic [7:0] cmd_get_status_q;

	// Frame state
	logic [CNT_W-1:0] byte_count_q;
	logic [7:0]       running_sum_q;
	logic [7:0]       header_q;
	logic [7:0]       address_q;
	logic [7:0]       command_q;
	logic [7:0]       check_q;
	logic [7:0]       key_q [KEY_COUNT];

	// Output register and skid entry
	logic out_valid_q;
	out_t out_data_q;
	logic skid_valid_q;
	out_t skid_data_q;

	logic [REG_IDX_W-1:0] reg_idx;
	logic                 cfg_wr;

	logic             in_fire;
	logic             out_fire;
	logic [CNT_W-1:0] pos;
	logic [7:0]       b;
	logic [7:0]       header_n;
	logic [7:0]       address_n;
	logic [7:0]       command_n;
	logic [7:0]       check_n;
	logic [7:0]       sum_n;
	logic [CNT_W-1:0] count_n;
	logic [7:0]       key_n [KEY_COUNT];
	logic [7:0]       res_key [OUT_KEYS];
	logic [1:0]       status_n;
	logic             cmd_known;
	out_t             result;

	// Configuration port
	assign pready  = 1'b1;
	assign reg_idx = paddr[PADDR_W-1:2];
	assign cfg_wr  = psel & penable & pwrite & pready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			local_address_q  <= '0;
			request_header_q <= '0;
			cmd_set_keys_q   <= '0;
			cmd_stop_reset_q <= '0;
			cmd_get_status_q <= '0;
		end else if (cfg_wr) begin
			unique case (reg_idx)
				REG_LOCAL_ADDRESS:  local_address_q  <= pwdata[7:0];
				REG_REQUEST_HEADER: request_header_q <= pwdata[7:0];
				REG_CMD_SET_KEYS:   cmd_set_keys_q   <= pwdata[7:0];
				REG_CMD_STOP_RESET: cmd_stop_reset_q <= pwdata[7:0];
				REG_CMD_GET_STATUS: cmd_get_status_q <= pwdata[7:0];
				default: ;
			endcase
		end
	end

	// Read back the addressed register
	always_comb begin
		unique case (reg_idx)
			REG_LOCAL_ADDRESS:  prdata = {24'd0, local_address_q};
			REG_REQUEST_HEADER: prdata = {24'd0, request_header_q};
			REG_CMD_SET_KEYS:   prdata = {24'd0, cmd_set_keys_q};
			REG_CMD_STOP_RESET: prdata = {24'd0, cmd_stop_reset_q};
			REG_CMD_GET_STATUS: prdata = {24'd0, cmd_get_status_q};
			default:            prdata = '0;
		endcase
	end

	// Handshakes
	assign in_stall  = skid_valid_q;
	assign in_fire   = in_valid & ~in_stall;
	assign out_fire  = out_valid_q & ~out_stall;
	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

	// Next frame state for the byte at the input
	assign pos = byte_count_q;
	assign b   = in_data.rx_byte;

	always_comb begin
		header_n  = (pos == CNT_W'(0)) ? b : header_q;
		address_n = (pos == CNT_W'(1)) ? b : address_q;
		command_n = (pos == CNT_W'(2)) ? b : command_q;
		check_n   = (pos == CNT_W'(FRAME_LEN - 1)) ? b : check_q;
		sum_n     = (pos < CNT_W'(FRAME_LEN - 1)) ? running_sum_q + b : running_sum_q;
		count_n   = (pos < CNT_W'(FRAME_LEN + 1)) ? pos + CNT_W'(1) : pos;
	end

	for (genvar i = 0; i < KEY_COUNT; i++) begin : g_key
		assign key_n[i] = (pos == CNT_W'(3 + i)) ? b : key_q[i];
	end

	// Check length and header, then checksum, address and command
	assign cmd_known = (command_n == cmd_set_keys_q) || (command_n == cmd_stop_reset_q)
		|| (command_n == cmd_get_status_q);

	always_comb begin
		if (count_n != CNT_W'(FRAME_LEN) || header_n != request_header_q) begin
			status_n = ST_CMD;
		end else if (sum_n != check_n) begin
			status_n = ST_SUM;
		end else if (address_n != local_address_q) begin
			status_n = ST_ADDR;
		end else if (!cmd_known) begin
			status_n = ST_CMD;
		end else begin
			status_n = ST_OK;
		end
	end

	for (genvar j = 0; j < OUT_KEYS; j++) begin : g_res_key
		if (j < KEY_COUNT) begin : g_used
			assign res_key[j] = (status_n == ST_OK) ? key_n[j] : 8'd0;
		end else begin : g_unused
			assign res_key[j] = 8'd0;
		end
	end

	always_comb begin
		result.status        = status_n;
		result.frame_address = (status_n == ST_OK) ? address_n : 8'd0;
		result.frame_command = (status_n == ST_OK) ? command_n : 8'd0;
		result.key_zero      = res_key[0];
		result.key_one       = res_key[1];
		result.key_two       = res_key[2];
		result.key_three     = res_key[3];
		result.key_four      = res_key[4];
	end

	// Advance frame state on each input transfer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			byte_count_q  <= '0;
			running_sum_q <= '0;
			header_q      <= '0;
			address_q     <= '0;
			command_q     <= '0;
			check_q       <= '0;
		end else if (in_fire) begin
			header_q  <= header_n;
			address_q <= address_n;
			command_q <= command_n;
			check_q   <= check_n;
			if (in_data.frame_end) begin
				byte_count_q  <= '0;
				running_sum_q <= '0;
			end else begin
				byte_count_q  <= count_n;
				running_sum_q <= sum_n;
			end
		end
	end

	// Key bytes hold no reset value
	always_ff @(posedge clk) begin
		if (in_fire) begin
			for (int i = 0; i < KEY_COUNT; i++) begin
				key_q[i] <= key_n[i];
			end
		end
	end

	// Output register with skid entry
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (out_fire) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (in_fire && in_data.frame_end) begin
			if (!out_valid_q || out_fire) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (out_fire) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (out_fire) begin
				out_data_q <= skid_data_q;
			end
		end else if (in_fire && in_data.frame_end) begin
			if (!out_valid_q || out_fire) begin
				out_data_q <= result;
			end else begin
				skid_data_q <= result;
			end
		end
	end

endmodule

// ----- rtl/acfp_checker.sv -----
// Port-level checker for the addressed command frame parser, with its bind.
module acfp_checker
	import acfp_pkg::*;
(
	input logic clk,
	input logic arst_n,
	input logic in_valid,
	input logic in_stall,
	input in_t  in_data,
	input logic out_valid,
	input logic out_stall,
	input out_t out_data
);

	// Hold a stalled result
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid)
		else $error("result dropped while stalled");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> $stable(out_data))
		else $error("stalled result changed");

	// Fields are zero unless status is ok
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_data.status != ST_OK |->
			out_data.frame_address == 8'd0 && out_data.frame_command == 8'd0
			&& out_data.key_zero == 8'd0 && out_data.key_one == 8'd0
			&& out_data.key_two == 8'd0 && out_data.key_three == 8'd0
			&& out_data.key_four == 8'd0)
		else $error("fields not cleared on error status");

	// A frame end into an empty output shows a result next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && in_data.frame_end && !out_valid |=> out_valid)
		else $error("frame end gave no result");

	// A mid-frame byte into an empty output gives no result
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !in_data.frame_end && !out_valid |=> !out_valid)
		else $error("result without frame end");

endmodule

bind addressed_command_frame_parser acfp_checker u_acfp_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.in_data   (in_data),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.out_data  (out_data)
);

// ----- test/tb_top.sv -----
// Self-checking testbench for the addressed command frame parser.
module tb_top;
	import acfp_pkg::*;

	localparam int KEYS = 5;
	localparam int FRAME_LEN = KEYS + 4;
	localparam int CYCLE_LIMIT = 300000;

	logic               clk;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_stall;
	in_t                in_data = '0;
	logic               out_valid;
	logic               out_stall = 1'b0;
	out_t               out_data;
	logic               psel = 1'b0;
	logic               penable = 1'b0;
	logic               pwrite = 1'b0;
	logic [PADDR_W-1:0] paddr = '0;
	logic [31:0]        pwdata = '0;
	logic [31:0]        prdata;
	logic               pready;

	addressed_command_frame_parser #(.KEY_COUNT(KEYS)) dut (
		.clk(clk),
		.arst_n(arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.in_data(in_data),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data(out_data),
		.psel(psel),
		.penable(penable),
		.pwrite(pwrite),
		.paddr(paddr),
		.pwdata(pwdata),
		.prdata(prdata),
		.pready(pready)
	);

	// Register copies
	logic [7:0] cfg_addr = '0;
	logic [7:0] cfg_hdr = '0;
	logic [7:0] cfg_set = '0;
	logic [7:0] cfg_stop = '0;
	logic [7:0] cfg_status = '0;

	// Frame capture state
	int         frame_pos = 0;
	logic [7:0] frame_sum = '0;
	logic [7:0] cap_hdr = '0;
	logic [7:0] cap_addr = '0;
	logic [7:0] cap_cmd = '0;
	logic [7:0] cap_keys [KEYS];
	logic [7:0] cap_chk = '0;

	out_t parse_results [$];
	out_t want;
	int   errors = 0;
	int   bytes_sent = 0;
	int   cycle_count = 0;
	int   stall_left = 0;
	bit   quiet = 1'b0;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	// End the run if it hangs
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("FAIL addressed_command_frame_parser");
		$finish;
	end

	function automatic int idle_len();
		if ($urandom_range(0, 99) < 85)
			return $urandom_range(1, 3);
		return $urandom_range(8, 30);
	endfunction

	function automatic int idle_gap();
		if (quiet || $urandom_range(0, 2) != 0)
			return 0;
		return idle_len();
	endfunction

	function automatic logic [7:0] rand_byte();
		int r;
		r = $urandom_range(0, 7);
		if (r == 0)
			return 8'h00;
		if (r == 1)
			return 8'hFF;
		return 8'($urandom_range(0, 255));
	endfunction

	// Stall the result side in random bursts
	always @(posedge clk) begin
		if (stall_left == 0 && !quiet && $urandom_range(0, 4) == 0)
			stall_left = idle_len();
		out_stall <= (stall_left != 0);
		if (stall_left != 0)
			stall_left--;
	end

	// Advance the frame state by one byte; queue the result at frame end
	task automatic predict_byte(input logic [7:0] b, input logic last);
		out_t       r;
		logic [1:0] st;
		int         pos;
		pos = frame_pos;
		if (pos == 0) begin
			cap_hdr = b;
		end else if (pos == 1) begin
			cap_addr = b;
		end else if (pos == 2) begin
			cap_cmd = b;
		end else if (pos < 3 + KEYS) begin
			cap_keys[pos - 3] = b;
		end else if (pos == FRAME_LEN - 1) begin
			cap_chk = b;
		end
		if (pos < FRAME_LEN - 1)
			frame_sum = frame_sum + b;
		if (pos < FRAME_LEN + 1)
			frame_pos = pos + 1;
		if (last) begin
			if (frame_pos != FRAME_LEN || cap_hdr != cfg_hdr)
				st = ST_CMD;
			else if (frame_sum != cap_chk)
				st = ST_SUM;
			else if (cap_addr != cfg_addr)
				st = ST_ADDR;
			else if (cap_cmd != cfg_set && cap_cmd != cfg_stop && cap_cmd != cfg_status)
				st = ST_CMD;
			else
				st = ST_OK;
			r = '0;
			r.status = st;
			if (st == ST_OK) begin
				r.frame_address = cap_addr;
				r.frame_command = cap_cmd;
				r.key_zero = cap_keys[0];
				r.key_one = cap_keys[1];
				r.key_two = cap_keys[2];
				r.key_three = cap_keys[3];
				r.key_four = cap_keys[4];
			end
			parse_results.push_back(r);
			frame_pos = 0;
			frame_sum = '0;
		end
	endtask

	// Send one byte transfer, then idle for a random gap
	task automatic send_byte(input logic [7:0] b, input logic last);
		int gap;
		in_data <= in_t'{rx_byte: b, frame_end: last};
		in_valid <= 1'b1;
		do @(posedge clk); while (in_stall);
		predict_byte(b, last);
		bytes_sent++;
		gap = idle_gap();
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
	endtask

	task automatic send_frame(input logic [7:0] fr [$]);
		foreach (fr[i])
			send_byte(fr[i], i == fr.size() - 1);
	endtask

	task automatic check_field(input string label, input logic [7:0] exp_v,
			input logic [7:0] got_v);
		if (got_v !== exp_v) begin
			$display("%0t: %s expected %h actual %h", $time, label, exp_v, got_v);
			errors++;
		end
	endtask

	// Compare each result transfer with the oldest expectation
	always @(posedge clk) begin
		if (arst_n && out_valid && !out_stall) begin
			if (parse_results.size() == 0) begin
				$display("%0t: result expected none actual %p", $time, out_data);
				errors++;
			end else begin
				want = parse_results.pop_front();
				check_field("status", {6'd0, want.status}, {6'd0, out_data.status});
				check_field("frame_address", want.frame_address, out_data.frame_address);
				check_field("frame_command", want.frame_command, out_data.frame_command);
				check_field("key_zero", want.key_zero, out_data.key_zero);
				check_field("key_one", want.key_one, out_data.key_one);
				check_field("key_two", want.key_two, out_data.key_two);
				check_field("key_three", want.key_three, out_data.key_three);
				check_field("key_four", want.key_four, out_data.key_four);
			end
		end
	end

	// Drop valid and wait until every result has come back
	task automatic drain();
		in_valid <= 1'b0;
		quiet = 1'b0;
		while (parse_results.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	// Write a register, then read it back
	task automatic reg_write(input logic [REG_IDX_W-1:0] idx, input logic [7:0] value);
		psel <= 1'b1;
		penable <= 1'b0;
		pwrite <= 1'b1;
		paddr <= {idx, 2'b00};
		pwdata <= {24'd0, value};
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		penable <= 1'b0;
		pwrite <= 1'b0;
		@(posedge clk);
		penable <= 1'b1;
		@(posedge clk);
		if (prdata[7:0] !== value) begin
			$display("%0t: register %0d expected %h actual %h", $time, idx, value,
				prdata[7:0]);
			errors++;
		end
		psel <= 1'b0;
		penable <= 1'b0;
		case (idx)
			REG_LOCAL_ADDRESS:  cfg_addr = value;
			REG_REQUEST_HEADER: cfg_hdr = value;
			REG_CMD_SET_KEYS:   cfg_set = value;
			REG_CMD_STOP_RESET: cfg_stop = value;
			default:            cfg_status = value;
		endcase
	endtask

	task automatic set_config(input logic [7:0] addr, input logic [7:0] hdr,
			input logic [7:0] c_set, input logic [7:0] c_stop, input logic [7:0] c_status);
		drain();
		reg_write(REG_LOCAL_ADDRESS, addr);
		reg_write(REG_REQUEST_HEADER, hdr);
		reg_write(REG_CMD_SET_KEYS, c_set);
		reg_write(REG_CMD_STOP_RESET, c_stop);
		reg_write(REG_CMD_GET_STATUS, c_status);
		@(posedge clk);
	endtask

	// Build one frame: mostly well formed, some corrupted, some raw noise
	task automatic random_frame();
		logic [7:0] fr [$];
		logic [7:0] acc;
		int         kind;
		int         n;
		if (quiet)
			quiet = ($urandom_range(0, 3) != 0);
		else
			quiet = ($urandom_range(0, 11) == 0);
		kind = $urandom_range(0, 99);
		if (kind < 10) begin
			n = $urandom_range(1, 20);
			repeat (n)
				send_byte(rand_byte(), $urandom_range(0, 7) == 0);
		end else begin
			fr.push_back(cfg_hdr);
			fr.push_back(cfg_addr);
			case ($urandom_range(0, 3))
				0:       fr.push_back(cfg_set);
				1:       fr.push_back(cfg_stop);
				2:       fr.push_back(cfg_status);
				default: fr.push_back(rand_byte());
			endcase
			repeat (KEYS)
				fr.push_back(rand_byte());
			kind = $urandom_range(0, 99);
			// corrupt header or address before the sum so only that check trips
			if (kind >= 55 && kind < 63)
				fr[0] = fr[0] ^ 8'($urandom_range(1, 255));
			else if (kind >= 63 && kind < 71)
				fr[1] = fr[1] ^ 8'($urandom_range(1, 255));
			acc = '0;
			foreach (fr[i])
				acc = acc + fr[i];
			fr.push_back(acc);
			if (kind >= 71 && kind < 79) begin
				fr[FRAME_LEN - 1] = fr[FRAME_LEN - 1] ^ 8'($urandom_range(1, 255));
			end else if (kind >= 79 && kind < 89) begin
				n = $urandom_range(1, FRAME_LEN - 1);
				while (fr.size() > n)
					void'(fr.pop_back());
			end else if (kind >= 89) begin
				repeat ($urandom_range(1, 4))
					fr.push_back(rand_byte());
			end
			send_frame(fr);
		end
	endtask

	task automatic random_traffic(input int n_items);
		int stop_at;
		stop_at = bytes_sent + n_items;
		while (bytes_sent < stop_at)
			random_frame();
	endtask

	// Reset registers are all zero, so an all-zero frame parses clean
	task automatic test_reset_values();
		logic [7:0] fr [$];
		repeat (FRAME_LEN)
			fr.push_back(8'h00);
		send_frame(fr);
		// single byte frame: wrong length
		send_byte(8'hFF, 1'b1);
		drain();
	endtask

	// All-ones registers with a frame that runs one byte past the check byte
	task automatic test_frame_limits();
		logic [7:0] fr [$];
		set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		fr = '{8'hFF, 8'hFF, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFF, 8'h00, 8'hFB, 8'h00};
		send_frame(fr);
		drain();
	endtask

	// All three command codes equal
	task automatic test_equal_codes();
		set_config(8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'hFF);
		random_traffic(280);
		drain();
	endtask

	task automatic test_extreme_config();
		set_config(8'h00, 8'hFF, 8'h00, 8'hFF, 8'h80);
		random_traffic(280);
		drain();
	endtask

	task automatic test_random_config();
		repeat (2) begin
			set_config(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
				8'($urandom_range(0, 255)));
			random_traffic(300);
		end
		drain();
	endtask

	initial begin
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);
		test_reset_values();
		test_frame_limits();
		test_equal_codes();
		test_extreme_config();
		test_random_config();
		drain();
		if (errors == 0)
			$display("PASS addressed_command_frame_parser");
		else
			$display("FAIL addressed_command_frame_parser");
		$finish;
	end

endmodule
